// ===== rtl/core/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open-address hash table: table geometry,
// field widths, action and status codes, controller/datapath signal groups.
// ----------------------------------------------------------------------------
package oaht_pkg;

	// table geometry, slot count is a power of two
	localparam int SLOTS   = 256;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = IDX_W + 1;

	localparam int KEY_W   = 32;
	localparam int HASH_W  = 32;
	localparam int VALUE_W = 32;

	// slot word: tombstone flag above the key
	localparam int SLOT_W  = KEY_W + 1;

	localparam int LIMIT_W = 9;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(192);

	// compare width for live count against the load limit
	localparam int CMP_W = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_GET    = 2'd2,
		ACT_SET    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;  // request taken, first slot read issued
		logic check;   // slot data valid this cycle, evaluate it
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic early;      // request answered without probing
		logic probe_end;  // probe stops on the slot checked this cycle
	} ctl_sts_t;

endpackage

// ===== rtl/core/oaht_ram.sv =====
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/oaht_ctrl.sv =====
// ----------------------------------------------------------------------------
// oaht_ctrl
// Request sequencer: takes a request, walks the probe one slot per cycle
// until the datapath reports the end of the probe.
// ----------------------------------------------------------------------------
module oaht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  oaht_pkg::ctl_sts_t sts,
	output oaht_pkg::ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_CHECK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.check  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (!sts.early) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.probe_end) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/core/oaht_dp.sv =====
// ----------------------------------------------------------------------------
// oaht_dp
// Hash table datapath: slot and value memories, per-slot valid bits, probe
// index and visit counter, first-tombstone tracking, counters and result.
// ----------------------------------------------------------------------------
module oaht_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  oaht_pkg::ctl_cmd_t                cmd,
	output oaht_pkg::ctl_sts_t                sts,
	input  logic [1:0]                        action,
	input  logic [oaht_pkg::KEY_W-1:0]        key,
	input  logic [oaht_pkg::HASH_W-1:0]       key_hash,
	input  logic [oaht_pkg::VALUE_W-1:0]      value_in,
	input  logic                              cfg_we,
	input  logic [oaht_pkg::LIMIT_W-1:0]      cfg_wdata,
	output logic [1:0]                        status,
	output logic [oaht_pkg::VALUE_W-1:0]      value_out,
	output logic                              done
);

	localparam int IDX_W = oaht_pkg::IDX_W;
	localparam int CNT_W = oaht_pkg::CNT_W;
	localparam int CMP_W = oaht_pkg::CMP_W;

	// request registers
	oaht_pkg::action_t               action_q;
	logic [oaht_pkg::KEY_W-1:0]      key_q;
	logic [oaht_pkg::VALUE_W-1:0]    val_q;

	// probe state
	logic [IDX_W-1:0]                idx_q;
	logic [IDX_W-1:0]                visit_q;
	logic                            tomb_found_q;
	logic [IDX_W-1:0]                tomb_idx_q;

	// table bookkeeping
	logic [oaht_pkg::SLOTS-1:0]      valid_q;
	logic [CNT_W-1:0]                live_q;
	logic [oaht_pkg::LIMIT_W-1:0]    limit_q;

	// memory ports
	logic [IDX_W-1:0]                rd_addr;
	logic [IDX_W-1:0]                wr_addr;
	logic                            slot_we;
	logic [oaht_pkg::SLOT_W-1:0]     slot_wdata;
	logic [oaht_pkg::SLOT_W-1:0]     slot_rd_s1;
	logic                            val_we;
	logic [oaht_pkg::VALUE_W-1:0]    val_rd_s1;
	logic                            valid_rd_s1;

	// slot evaluation
	logic [oaht_pkg::KEY_W-1:0]      cur_key;
	logic                            cur_tomb;
	logic                            cur_empty;
	logic                            cur_hit;
	logic                            last_visit;
	logic                            have_tomb;
	logic [IDX_W-1:0]                tomb_sel;
	logic                            probe_end;
	logic                            finish;
	logic                            live_inc;

	// early answer
	logic                            would_overflow;
	oaht_pkg::status_t               early_status;

	oaht_pkg::status_t               res_status;
	oaht_pkg::status_t               status_q;
	logic [oaht_pkg::VALUE_W-1:0]    res_value;
	logic [oaht_pkg::VALUE_W-1:0]    value_out_q;
	logic                            done_q;

	assign rd_addr = cmd.accept ? key_hash[IDX_W-1:0] : IDX_W'(idx_q + 1'b1);

	oaht_ram #(
		.WIDTH (oaht_pkg::SLOT_W),
		.DEPTH (oaht_pkg::SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (wr_addr),
		.wdata (slot_wdata),
		.raddr (rd_addr),
		.rdata (slot_rd_s1)
	);

	oaht_ram #(
		.WIDTH (oaht_pkg::VALUE_W),
		.DEPTH (oaht_pkg::SLOTS)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (wr_addr),
		.wdata (val_q),
		.raddr (rd_addr),
		.rdata (val_rd_s1)
	);

	always_ff @(posedge clk) begin
		valid_rd_s1 <= valid_q[rd_addr];
	end

	// never-written slots read as empty
	assign cur_key    = valid_rd_s1 ? slot_rd_s1[oaht_pkg::KEY_W-1:0] : '0;
	assign cur_tomb   = valid_rd_s1 & slot_rd_s1[oaht_pkg::KEY_W];
	assign cur_empty  = (cur_key == '0) && !cur_tomb;
	assign cur_hit    = (cur_key == key_q);
	assign last_visit = (visit_q == {IDX_W{1'b1}});
	assign have_tomb  = tomb_found_q | cur_tomb;
	assign tomb_sel   = tomb_found_q ? tomb_idx_q : idx_q;

	assign probe_end = cur_empty | cur_hit | last_visit;
	assign finish    = cmd.check & probe_end;

	assign would_overflow = (CMP_W'(live_q) + CMP_W'(1)) > CMP_W'(limit_q);

	always_comb begin
		sts.probe_end = probe_end;
		sts.early     = 1'b0;
		early_status  = oaht_pkg::ST_ABSENT;
		if (key == '0) begin
			sts.early = 1'b1;
		end else if (oaht_pkg::action_t'(action) == oaht_pkg::ACT_INSERT) begin
			if (would_overflow) begin
				sts.early    = 1'b1;
				early_status = oaht_pkg::ST_FULL;
			end
		end else if (live_q == '0) begin
			sts.early = 1'b1;
		end
	end

	// end-of-probe decision and table update
	always_comb begin
		res_status = oaht_pkg::ST_ABSENT;
		res_value  = '0;
		slot_we    = 1'b0;
		val_we     = 1'b0;
		wr_addr    = idx_q;
		slot_wdata = {1'b0, key_q};
		live_inc   = 1'b0;
		if (finish) begin
			case (action_q)
				oaht_pkg::ACT_INSERT: begin
					if (cur_hit) begin
						res_status = oaht_pkg::ST_PRESENT;
					end else if (have_tomb) begin
						// revive the first tombstone passed
						res_status = oaht_pkg::ST_DONE;
						wr_addr    = tomb_sel;
						slot_we    = 1'b1;
						val_we     = 1'b1;
					end else if (cur_empty) begin
						res_status = oaht_pkg::ST_DONE;
						slot_we    = 1'b1;
						val_we     = 1'b1;
						live_inc   = 1'b1;
					end else begin
						res_status = oaht_pkg::ST_FULL;
					end
				end
				oaht_pkg::ACT_REMOVE: begin
					if (cur_hit) begin
						res_status = oaht_pkg::ST_DONE;
						slot_we    = 1'b1;
						slot_wdata = {1'b1, {oaht_pkg::KEY_W{1'b0}}};
					end
				end
				oaht_pkg::ACT_GET: begin
					if (cur_hit) begin
						res_status = oaht_pkg::ST_DONE;
						res_value  = val_rd_s1;
					end
				end
				oaht_pkg::ACT_SET: begin
					if (cur_hit) begin
						res_status = oaht_pkg::ST_DONE;
						val_we     = 1'b1;
					end
				end
				default: begin
					res_status = oaht_pkg::ST_ABSENT;
				end
			endcase
		end
	end

	// request and probe registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q     <= oaht_pkg::action_t'(action);
			key_q        <= key;
			val_q        <= value_in;
			idx_q        <= key_hash[IDX_W-1:0];
			visit_q      <= '0;
			tomb_found_q <= 1'b0;
		end else if (cmd.check) begin
			idx_q   <= IDX_W'(idx_q + 1'b1);
			visit_q <= IDX_W'(visit_q + 1'b1);
			if (cur_tomb && !tomb_found_q) begin
				tomb_found_q <= 1'b1;
				tomb_idx_q   <= idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q  <= '0;
			limit_q <= oaht_pkg::LIMIT_RESET;
		end else begin
			if (slot_we) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (live_inc) begin
				live_q <= CNT_W'(live_q + 1'b1);
			end
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.accept & sts.early) | finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.early) begin
			status_q    <= early_status;
			value_out_q <= '0;
		end else if (finish) begin
			status_q    <= res_status;
			value_out_q <= res_value;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign value_out = value_out_q;

endmodule

// ===== rtl/core/open_address_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// open_address_hash_table_top
// Hash table with linear probing and tombstones: insert, remove, get, set.
//
// Request channel: a request (action, key, key_hash, value_in) transfers at a
// rising edge with start high and busy low. Result channel: status and
// value_out are valid for one cycle while done is high; there is no
// backpressure, the result transfers in that cycle.
// A probe that visits N slots gives done after its last slot is checked;
// requests answered without a probe (zero key, insert over the load
// limit, lookups on a table that never held an entry) give done in the
// cycle after the transfer. busy stays high while the probe runs, so no new
// request is taken; the probe reads one slot per cycle through the single
// read port of the slot memory, and N runs from 1 up to the slot count.
// The load limit is written through cfg_we/cfg_wdata while no request is in
// flight; it takes effect for the next request.
// Reset: the table is empty, the live count is zero and the load limit is
// 192. Per-slot valid bits clear at once, so requests are taken in the first
// cycle after reset.
// ----------------------------------------------------------------------------
module open_address_hash_table_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        action,
	input  logic [oaht_pkg::KEY_W-1:0]        key,
	input  logic [oaht_pkg::HASH_W-1:0]       key_hash,
	input  logic [oaht_pkg::VALUE_W-1:0]      value_in,
	input  logic                              cfg_we,
	input  logic [oaht_pkg::LIMIT_W-1:0]      cfg_wdata,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [oaht_pkg::VALUE_W-1:0]      value_out
);

	oaht_pkg::ctl_cmd_t cmd;
	oaht_pkg::ctl_sts_t sts;

	oaht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	oaht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.action    (action),
		.key       (key),
		.key_hash  (key_hash),
		.value_in  (value_in),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.value_out (value_out),
		.done      (done)
	);

endmodule
